/* rtl/gbs_pkg.sv */
// Shared types, constants and the fixed Gaussian kernel of the stream blur.
// No dependencies; imported by the top level, gbs_ctrl, gbs_conv and the testbench.
package gbs_pkg;

  localparam int KSIZE            = 11;
  localparam int RAD              = KSIZE / 2;
  localparam int KB               = $clog2(KSIZE);
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WEIGHT_W         = 12;
  localparam int PIX_W            = 24;
  localparam int CFG_W            = 12;
  localparam int CFG_IDX_W        = 1;
  localparam int PROD_W           = 8 + WEIGHT_W;
  localparam int ROW_W            = PROD_W + 4;
  localparam int TOT_W            = ROW_W + 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Q0.16 weights of the normalized 11x11 Gaussian (sigma = 11/6), indexed
  // by the absolute row and column distance from the window center.
  localparam logic [WEIGHT_W-1:0] KERNEL_TAB [RAD+1][RAD+1] = '{
    '{12'd3118, 12'd2687, 12'd1720, 12'd817, 12'd289, 12'd76},
    '{12'd2687, 12'd2316, 12'd1482, 12'd704, 12'd249, 12'd65},
    '{12'd1720, 12'd1482, 12'd949,  12'd451, 12'd159, 12'd42},
    '{12'd817,  12'd704,  12'd451,  12'd214, 12'd76,  12'd20},
    '{12'd289,  12'd249,  12'd159,  12'd76,  12'd27,  12'd7},
    '{12'd76,   12'd65,   12'd42,   12'd20,  12'd7,   12'd2}
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Per-word decisions taken when a word is accepted.
  typedef struct packed {
    logic          wr_en;
    logic [KB-1:0] wr_bank;
    logic [KB-1:0] base;
    logic          has_out;
    logic          border;
    logic          last;
  } ctl_t;

  // Column assembly controls that travel with the line store read.
  typedef struct packed {
    logic [KB-1:0] base;
    logic          fwd;
    logic [KB-1:0] fwd_bank;
    pixel_t        fwd_pix;
  } sel_t;

  typedef struct packed {
    logic border;
    logic last;
  } tag_t;

  function automatic logic [WEIGHT_W-1:0] kernel_weight(input int ky, input int kx);
    int dy;
    int dx;
    dy = (ky > RAD) ? ky - RAD : RAD - ky;
    dx = (kx > RAD) ? kx - RAD : RAD - kx;
    return KERNEL_TAB[dy][dx];
  endfunction

endpackage

/* rtl/gaussian_blur_stream.sv */
// Streaming 11x11 Gaussian blur over RGB pixels in raster order.
// Throughput: one word per cycle in and out; an output stall fills the pipe and then
// stalls the input. Results trail inputs by RAD rows plus RAD words (drain words flush
// them) and pass through every pipeline stage listed below.
// Reset: asynchronous, active low; clears positions and valids, sets the sizes to
// 640 x 480. Line store contents are undefined until written; no clearing pass.
module gaussian_blur_stream #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [gbs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gbs_pkg::CFG_W-1:0]       cfg_data_i,
  // input words
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      in_blue_i,
  input  logic [7:0]                      in_green_i,
  input  logic [7:0]                      in_red_i,
  input  logic                            drain_i,
  // result words
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      out_blue_o,
  output logic [7:0]                      out_green_o,
  output logic [7:0]                      out_red_o,
  output logic                            frame_end_o
);
  import gbs_pkg::*;

  localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
  localparam int H_BITS   = $clog2(MAX_HEIGHT + 1);
  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int IDX_BITS = $clog2(RAD * MAX_WIDTH + RAD + 1);

  // ---------------------------------------------------------------------------
  // Size registers and their effective values: zero acts as one, anything
  // beyond the build maximum clamps to it.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]    width_q, height_q;
  logic [W_BITS-1:0]   eff_w;
  logic [H_BITS-1:0]   eff_h;
  logic [IDX_BITS-1:0] lag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(640);
      height_q <= CFG_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      eff_w = W_BITS'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = W_BITS'(MAX_WIDTH);
    end else begin
      eff_w = W_BITS'(width_q);
    end
    if (height_q == '0) begin
      eff_h = H_BITS'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      eff_h = H_BITS'(MAX_HEIGHT);
    end else begin
      eff_h = H_BITS'(height_q);
    end
    // Words to accept before the first result: RAD rows plus RAD pixels.
    lag = IDX_BITS'(eff_w) * IDX_BITS'(RAD) + IDX_BITS'(RAD);
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake. Stages:
  //   1: line store read data      2: window holds the item
  //   3: products                  4: row sums
  //   5: window sums               6: output register
  // Each stage takes a new item when it is empty or its item moves on, so
  // the input flows while a result waits in the output register, until the pipe fills.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic acc;

  assign rdy6 = !v6_q || !out_stall_i;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o = !rdy1;
  assign acc        = in_valid_i && rdy1;

  // ---------------------------------------------------------------------------
  // Position tracking and line store addressing.
  // ---------------------------------------------------------------------------
  ctl_t                ctl;
  logic [COL_BITS-1:0] wr_addr, rd_addr;
  pixel_t              in_pix;

  assign in_pix = '{red: in_red_i, green: in_green_i, blue: in_blue_i};

  gbs_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .drain_i  (drain_i),
    .width_i  (eff_w),
    .height_i (eff_h),
    .lag_i    (lag),
    .ctl_o    (ctl),
    .wr_addr_o(wr_addr),
    .rd_addr_o(rd_addr)
  );

  // ---------------------------------------------------------------------------
  // Line store: one bank per row slot (row mod KSIZE). Every accepted word reads one
  // whole column of all banks; in-frame non-drain words also write into their bank.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] bank_rd [KSIZE];

  for (genvar b = 0; b < KSIZE; b++) begin : g_bank
    gbs_ram #(
      .WIDTH(PIX_W),
      .DEPTH(MAX_WIDTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (acc && ctl.wr_en && ctl.wr_bank == KB'(b)),
      .waddr_i(wr_addr),
      .wdata_i(in_pix),
      .re_i   (acc),
      .raddr_i(rd_addr),
      .rdata_o(bank_rd[b])
    );
  end

  // Stage 1 side info: rotation base and a bypass for the word written in
  // the same cycle as the read (the RAM returns the old data then).
  sel_t sel1_q;
  logic has_out1_q, has_out2_q;
  tag_t tag1_q, tag2_q, tag3_q, tag4_q, tag5_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      sel1_q.base     <= ctl.base;
      sel1_q.fwd      <= ctl.wr_en && (wr_addr == rd_addr);
      sel1_q.fwd_bank <= ctl.wr_bank;
      sel1_q.fwd_pix  <= in_pix;
      has_out1_q      <= ctl.has_out;
      tag1_q          <= '{border: ctl.border, last: ctl.last};
    end
    if (v1_q && rdy2) begin
      has_out2_q <= has_out1_q;
      tag2_q     <= tag1_q;
    end
    if (v2_q && rdy3) begin
      tag3_q <= tag2_q;
    end
    if (v3_q && rdy4) begin
      tag4_q <= tag3_q;
    end
    if (v4_q && rdy5) begin
      tag5_q <= tag4_q;
    end
  end

  // Valid bits: advance on ready; drop words without a result after the
  // window has absorbed their column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q && has_out2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Window and filter arithmetic.
  // ---------------------------------------------------------------------------
  logic [7:0] sum_blue, sum_green, sum_red;

  gbs_conv u_conv (
    .clk_i   (clk_i),
    .win_en_i(v1_q && rdy2),
    .mul_en_i(v2_q && rdy3),
    .row_en_i(v3_q && rdy4),
    .tot_en_i(v4_q && rdy5),
    .bank_i  (bank_rd),
    .sel_i   (sel1_q),
    .blue_o  (sum_blue),
    .green_o (sum_green),
    .red_o   (sum_red)
  );

  // ---------------------------------------------------------------------------
  // Output register: zero any pixel whose window leaves the frame.
  // ---------------------------------------------------------------------------
  logic [7:0] out_blue_q, out_green_q, out_red_q;
  logic       frame_end_q;

  always_ff @(posedge clk_i) begin
    if (v5_q && rdy6) begin
      out_blue_q  <= tag5_q.border ? 8'd0 : sum_blue;
      out_green_q <= tag5_q.border ? 8'd0 : sum_green;
      out_red_q   <= tag5_q.border ? 8'd0 : sum_red;
      frame_end_q <= tag5_q.last;
    end
  end

  assign out_valid_o = v6_q;
  assign out_blue_o  = out_blue_q;
  assign out_green_o = out_green_q;
  assign out_red_o   = out_red_q;
  assign frame_end_o = frame_end_q;

endmodule

/* rtl/gbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address write; no dependencies.
module gbs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/gbs_ctrl.sv */
// Position counters of the blur: input and output raster positions, priming
// count and the per-word line store addresses. Depends on gbs_pkg.
module gbs_ctrl #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    acc_i,
  input  logic                                    drain_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]          width_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]         height_i,
  input  logic [$clog2(gbs_pkg::RAD*MAX_WIDTH+gbs_pkg::RAD+1)-1:0] lag_i,
  output gbs_pkg::ctl_t                           ctl_o,
  output logic [$clog2(MAX_WIDTH)-1:0]            wr_addr_o,
  output logic [$clog2(MAX_WIDTH)-1:0]            rd_addr_o
);
  import gbs_pkg::*;

  localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
  localparam int H_BITS   = $clog2(MAX_HEIGHT + 1);
  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int ROW_BITS = $clog2(MAX_HEIGHT);
  localparam int IDX_BITS = $clog2(RAD * MAX_WIDTH + RAD + 1);
  localparam int CW       = W_BITS + 1;
  localparam int RW       = H_BITS + 1;

  logic [COL_BITS-1:0] in_col_q, in_col_d;
  logic [H_BITS-1:0]   in_row_q, in_row_d;
  logic [KB-1:0]       in_rmod_q, in_rmod_d;
  logic [IDX_BITS-1:0] in_idx_q, in_idx_d;
  logic [COL_BITS-1:0] out_col_q, out_col_d;
  logic [ROW_BITS-1:0] out_row_q, out_row_d;
  logic [KB-1:0]       out_rmod_q, out_rmod_d;

  logic          in_col_end, out_col_end, out_row_end;
  logic          col_wrap;
  logic [CW-1:0] ahead_col;
  logic [KB-1:0] rd_rmod;
  logic [KB:0]   base_sum;

  always_comb begin
    in_col_end  = (CW'(in_col_q) + CW'(1)) >= CW'(width_i);
    out_col_end = (CW'(out_col_q) + CW'(1)) >= CW'(width_i);
    out_row_end = (RW'(out_row_q) + RW'(1)) >= RW'(height_i);

    ctl_o.wr_en   = !drain_i && (in_row_q < height_i) && (CW'(in_col_q) < CW'(width_i));
    ctl_o.wr_bank = in_rmod_q;
    ctl_o.has_out = in_idx_q >= lag_i;
    ctl_o.last    = ctl_o.has_out && out_col_end && out_row_end;
    ctl_o.border  = (RW'(out_row_q) < RW'(RAD)) || (CW'(out_col_q) < CW'(RAD)) ||
                    (RW'(out_row_q) + RW'(RAD) >= RW'(height_i)) ||
                    (CW'(out_col_q) + CW'(RAD) >= CW'(width_i));

    // Read the column RAD pixels ahead of the output position.
    ahead_col = CW'(out_col_q) + CW'(RAD);
    col_wrap  = ahead_col >= CW'(width_i);
    if (col_wrap) begin
      ahead_col = ahead_col - CW'(width_i);
    end
    rd_rmod = out_rmod_q;
    if (col_wrap) begin
      rd_rmod = (out_rmod_q == KB'(KSIZE - 1)) ? '0 : out_rmod_q + KB'(1);
    end
    base_sum = (KB + 1)'(rd_rmod) + (KB + 1)'(KSIZE - RAD);
    if (base_sum >= (KB + 1)'(KSIZE)) begin
      base_sum = base_sum - (KB + 1)'(KSIZE);
    end
    ctl_o.base = base_sum[KB-1:0];
    wr_addr_o  = in_col_q;
    rd_addr_o  = ahead_col[COL_BITS-1:0];

    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_rmod_d  = in_rmod_q;
    in_idx_d   = in_idx_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_rmod_d = out_rmod_q;

    if (acc_i) begin
      if (ctl_o.has_out) begin
        if (out_col_end) begin
          out_col_d = '0;
          if (!out_row_end) begin
            out_row_d  = out_row_q + ROW_BITS'(1);
            out_rmod_d = (out_rmod_q == KB'(KSIZE - 1)) ? '0 : out_rmod_q + KB'(1);
          end
        end else begin
          out_col_d = out_col_q + COL_BITS'(1);
        end
      end
      if (ctl_o.last) begin
        // Frame done: rewind every position.
        in_col_d   = '0;
        in_row_d   = '0;
        in_rmod_d  = '0;
        in_idx_d   = '0;
        out_col_d  = '0;
        out_row_d  = '0;
        out_rmod_d = '0;
      end else begin
        if (in_col_end) begin
          in_col_d  = '0;
          in_row_d  = (in_row_q == H_BITS'(MAX_HEIGHT)) ? in_row_q : in_row_q + H_BITS'(1);
          in_rmod_d = (in_rmod_q == KB'(KSIZE - 1)) ? '0 : in_rmod_q + KB'(1);
        end else begin
          in_col_d = in_col_q + COL_BITS'(1);
        end
        if (in_idx_q < lag_i) begin
          in_idx_d = in_idx_q + IDX_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_rmod_q  <= '0;
      in_idx_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_rmod_q <= '0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_rmod_q  <= in_rmod_d;
      in_idx_q   <= in_idx_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_rmod_q <= out_rmod_d;
    end
  end

endmodule

/* rtl/gbs_conv.sv */
// Window and filter datapath: column assembly from the line store banks,
// the KSIZE x KSIZE window shift line, and the registered multiply-add tree.
// Depends on gbs_pkg.
module gbs_conv (
  input  logic                      clk_i,
  input  logic                      win_en_i,
  input  logic                      mul_en_i,
  input  logic                      row_en_i,
  input  logic                      tot_en_i,
  input  logic [gbs_pkg::PIX_W-1:0] bank_i [gbs_pkg::KSIZE],
  input  gbs_pkg::sel_t             sel_i,
  output logic [7:0]                blue_o,
  output logic [7:0]                green_o,
  output logic [7:0]                red_o
);
  import gbs_pkg::*;

  localparam int SH_W = TOT_W - WEIGHT_FRAC_BITS;

  pixel_t             col   [KSIZE];
  pixel_t             win_q [KSIZE][KSIZE];
  logic [PROD_W-1:0]  prod_q [3][KSIZE][KSIZE];
  logic [ROW_W-1:0]   rsum_d [3][KSIZE];
  logic [ROW_W-1:0]   rsum_q [3][KSIZE];
  logic [TOT_W-1:0]   tsum_d [3];
  logic [TOT_W-1:0]   tsum_q [3];
  logic [7:0]         sat    [3];

  // Rotate the banks so that window row 0 is the top row; take the word
  // written in the read cycle from the bypass.
  always_comb begin
    logic [KB:0] b;
    for (int ky = 0; ky < KSIZE; ky++) begin
      b = (KB + 1)'(sel_i.base) + (KB + 1)'(ky);
      if (b >= (KB + 1)'(KSIZE)) begin
        b = b - (KB + 1)'(KSIZE);
      end
      if (sel_i.fwd && sel_i.fwd_bank == b[KB-1:0]) begin
        col[ky] = sel_i.fwd_pix;
      end else begin
        col[ky] = pixel_t'(bank_i[b[KB-1:0]]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_en_i) begin
      for (int ky = 0; ky < KSIZE; ky++) begin
        for (int kx = 0; kx < KSIZE - 1; kx++) begin
          win_q[ky][kx] <= win_q[ky][kx+1];
        end
        win_q[ky][KSIZE-1] <= col[ky];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      for (int ky = 0; ky < KSIZE; ky++) begin
        for (int kx = 0; kx < KSIZE; kx++) begin
          prod_q[0][ky][kx] <= PROD_W'(win_q[ky][kx].blue)  * PROD_W'(kernel_weight(ky, kx));
          prod_q[1][ky][kx] <= PROD_W'(win_q[ky][kx].green) * PROD_W'(kernel_weight(ky, kx));
          prod_q[2][ky][kx] <= PROD_W'(win_q[ky][kx].red)   * PROD_W'(kernel_weight(ky, kx));
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int ky = 0; ky < KSIZE; ky++) begin
        rsum_d[c][ky] = '0;
        for (int kx = 0; kx < KSIZE; kx++) begin
          rsum_d[c][ky] = rsum_d[c][ky] + ROW_W'(prod_q[c][ky][kx]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_en_i) begin
      rsum_q <= rsum_d;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tsum_d[c] = '0;
      for (int ky = 0; ky < KSIZE; ky++) begin
        tsum_d[c] = tsum_d[c] + TOT_W'(rsum_q[c][ky]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tot_en_i) begin
      tsum_q <= tsum_d;
    end
  end

  // Drop the fraction, clamp at full scale.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (tsum_q[c][TOT_W-1:WEIGHT_FRAC_BITS] > SH_W'(255)) begin
        sat[c] = 8'd255;
      end else begin
        sat[c] = tsum_q[c][WEIGHT_FRAC_BITS+7:WEIGHT_FRAC_BITS];
      end
    end
  end

  assign blue_o  = sat[0];
  assign green_o = sat[1];
  assign red_o   = sat[2];

endmodule

/* rtl/gbs_checker.sv */
// Port-level checks for the stream blur, bound to gaussian_blur_stream.
// Depends only on the top level's ports.
module gbs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_blue_o,
  input logic [7:0] out_green_o,
  input logic [7:0] out_red_o,
  input logic       frame_end_o
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_blue_o) &&
      $stable(out_green_o) && $stable(out_red_o) && $stable(frame_end_o))
    else $error("stalled result word changed");

  // Stall the input only when a finished word is blocked at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // The last pixel of a frame lies on the border, so it is black.
  a_last_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |->
      out_blue_o == 8'd0 && out_green_o == 8'd0 && out_red_o == 8'd0)
    else $error("frame end pixel not zero");

  // No result appears in the first cycle after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid straight out of reset");

endmodule

bind gaussian_blur_stream gbs_checker u_gbs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_blue_o (out_blue_o),
  .out_green_o(out_green_o),
  .out_red_o  (out_red_o),
  .frame_end_o(frame_end_o)
);

/* dv/testbench.sv */
// Self-checking bench for gaussian_blur_stream: whole frames plus drain tails.
// Depends on gbs_pkg and the block. Results are compared with a built-in blur predictor.
`timescale 1ns / 100ps

module testbench;
  import gbs_pkg::*;

  localparam int MAXW  = 2048;
  localparam int MAXH  = 2048;
  localparam int LIMIT = 2000000;

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       fend;
  } blur_word_t;

  // One directed frame: raw register values, pixel pattern, tail kind, zero-result flag.
  typedef enum int {PAT_ZERO, PAT_FULL, PAT_RANDOM, PAT_CHECKER} pattern_e;
  typedef struct {
    int       w;
    int       h;
    pattern_e pat;
    bit       pix_tail;
    bit       zero_exp;
  } frame_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [7:0]       in_blue_i = '0;
  logic [7:0]       in_green_i = '0;
  logic [7:0]       in_red_i = '0;
  logic             drain_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [7:0]       out_blue_o;
  logic [7:0]       out_green_o;
  logic [7:0]       out_red_o;
  logic             frame_end_o;

  gaussian_blur_stream u_top (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Predictor state: kernel, sizes, positions and the row store.
  longint unsigned  weights [KSIZE*KSIZE];
  logic [CFG_W-1:0] size_w = 12'd640;
  logic [CFG_W-1:0] size_h = 12'd480;
  int               in_col, in_row, out_col, out_row;
  logic [23:0]      rows_store [KSIZE*MAXW];
  blur_word_t       pending_words [$];
  int               errors = 0;
  int               cycles = 0;
  bit               calm = 0;
  int               sent_items = 0;

  function automatic longint gauss_q30(int d);
    longint one, num, den, term, acc;
    one  = longint'(1) << 30;
    num  = (KSIZE >= 6) ? 18 * d : d;
    den  = (KSIZE >= 6) ? KSIZE * KSIZE * 16 : 32;
    term = one;
    acc  = one;
    for (int k = 1; k <= 20; k++) begin
      term = term * num / (den * k);
      if (k % 2 == 1) acc -= term; else acc += term;
    end
    if (acc < 0) acc = 0;
    for (int i = 0; i < 4; i++) acc = (acc * acc + (one >> 1)) >> 30;
    return acc;
  endfunction

  function automatic void build_weights();
    longint unsigned vals [KSIZE*KSIZE];
    longint unsigned total;
    total = 0;
    for (int y = 0; y < KSIZE; y++)
      for (int x = 0; x < KSIZE; x++) begin
        vals[y*KSIZE+x] = gauss_q30((x-RAD)*(x-RAD) + (y-RAD)*(y-RAD));
        total += vals[y*KSIZE+x];
      end
    if (total == 0) total = 1;
    for (int i = 0; i < KSIZE*KSIZE; i++)
      weights[i] = ((vals[i] << WEIGHT_FRAC_BITS) + total / 2) / total;
  endfunction

  function automatic int eff_w();
    if (size_w == 0) return 1;
    return (size_w > MAXW) ? MAXW : int'(size_w);
  endfunction

  function automatic int eff_h();
    if (size_h == 0) return 1;
    return (size_h > MAXH) ? MAXH : int'(size_h);
  endfunction

  function automatic logic [7:0] clamp_channel(longint unsigned s);
    s = s >> WEIGHT_FRAC_BITS;
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  // Blur of one output position; zero inside the border band.
  function automatic blur_word_t blur_pixel(int oy, int ox, int w, int h);
    blur_word_t      r;
    longint unsigned sb, sg, sr, wt;
    logic [23:0]     p;
    int              base;
    sb = 0; sg = 0; sr = 0;
    r = '{8'd0, 8'd0, 8'd0, 1'b0};
    if (oy < RAD || ox < RAD || oy + RAD >= h || ox + RAD >= w) return r;
    for (int ky = 0; ky < KSIZE; ky++) begin
      base = ((oy + ky - RAD) % KSIZE) * MAXW;
      for (int kx = 0; kx < KSIZE; kx++) begin
        p  = rows_store[base + ox + kx - RAD];
        wt = weights[ky*KSIZE + kx];
        sb += p[7:0] * wt;
        sg += p[15:8] * wt;
        sr += p[23:16] * wt;
      end
    end
    r.blue  = clamp_channel(sb);
    r.green = clamp_channel(sg);
    r.red   = clamp_channel(sr);
    return r;
  endfunction

  // Advance the predictor by one accepted word; returns 1 when a result is due.
  function automatic bit blur_step(logic [7:0] b, logic [7:0] g, logic [7:0] rd,
                                   logic dr, output blur_word_t res);
    int w, h, lag, cur;
    bit last;
    w = eff_w();
    h = eff_h();
    lag = RAD * w + RAD;
    cur = in_row * w + in_col;
    last = 0;
    if (!dr && in_row < h && in_col < w)
      rows_store[(in_row % KSIZE) * MAXW + in_col] = {rd, g, b};
    if (cur >= lag) begin
      res = blur_pixel(out_row, out_col, w, h);
      if (out_col + 1 >= w) begin
        out_col = 0;
        if (out_row + 1 >= h) last = 1; else out_row++;
      end else begin
        out_col++;
      end
      res.fend = last;
      if (last) begin
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        return 1;
      end
    end
    if (in_col + 1 >= w) begin
      in_col = 0;
      if (in_row < 16'hFFFF) in_row++;
    end else begin
      in_col++;
    end
    return cur >= lag;
  endfunction

  // Present one word, hold it until accepted, then maybe idle a burst.
  task automatic send_word(logic [7:0] b, logic [7:0] g, logic [7:0] rd, logic dr,
                           bit zero_exp);
    blur_word_t res;
    bit         taken;
    in_valid_i <= 1'b1;
    in_blue_i  <= b;
    in_green_i <= g;
    in_red_i   <= rd;
    drain_i    <= dr;
    taken = 0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
    end
    if (blur_step(b, g, rd, dr, res)) begin
      if (zero_exp) begin
        res.blue = 0; res.green = 0; res.red = 0;
      end
      pending_words.push_back(res);
    end
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Write both size registers once the pipe has emptied.
  task automatic write_sizes(int w, int h);
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_IMAGE_WIDTH;
    cfg_data_i <= CFG_W'(w);
    @(posedge clk_i);
    size_w = CFG_W'(w);
    cfg_idx_i  <= REG_IMAGE_HEIGHT;
    cfg_data_i <= CFG_W'(h);
    @(posedge clk_i);
    size_h = CFG_W'(h);
    cfg_we_i <= 1'b0;
  endtask

  // Send a full frame followed by the tail that flushes its last results.
  task automatic run_frame(frame_row_t f, output int sent);
    int         w, h, tail;
    logic [7:0] b, g, rd;
    write_sizes(f.w, f.h);
    w = eff_w();
    h = eff_h();
    tail = RAD * w + RAD;
    sent = 0;
    for (int i = 0; i < w * h; i++) begin
      case (f.pat)
        PAT_ZERO: begin b = 0; g = 0; rd = 0; end
        PAT_FULL: begin b = 8'hFF; g = 8'hFF; rd = 8'hFF; end
        PAT_CHECKER: begin
          b  = ((i % w + i / w) % 2) ? 8'hFF : 8'h00;
          g  = ~b;
          rd = b ^ 8'hA5;
        end
        default: begin
          b = 8'($urandom); g = 8'($urandom); rd = 8'($urandom);
        end
      endcase
      send_word(b, g, rd, 1'b0, f.zero_exp);
      sent++;
    end
    // Pixel words past the frame end act as drain words.
    for (int i = 0; i < tail; i++) begin
      send_word(8'($urandom), 8'($urandom), 8'($urandom),
                f.pix_tail ? 1'($urandom_range(0, 1)) : 1'b1, f.zero_exp);
      sent++;
    end
  endtask

  // Directed frames: flat fields, smallest sizes, zero sizes, odd shapes.
  frame_row_t directed [7] = '{
    '{11, 11, PAT_ZERO,    0, 1},
    '{11, 11, PAT_FULL,    0, 0},
    '{12, 13, PAT_CHECKER, 0, 0},
    '{1,  1,  PAT_RANDOM,  0, 1},
    '{0,  0,  PAT_RANDOM,  1, 1},
    '{14, 12, PAT_RANDOM,  1, 0},
    '{11, 12, PAT_FULL,    1, 0}
  };

  initial begin
    int         sent;
    frame_row_t f;
    build_weights();
    for (int i = 0; i < KSIZE*MAXW; i++) rows_store[i] = '0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      run_frame(directed[i], sent);
      sent_items += sent;
    end
    // Random frames, mostly small; the last stretch runs without idling.
    while (sent_items < 1800) begin
      if (sent_items > 1500) calm = 1;
      f.w = $urandom_range(1, 26);
      f.h = $urandom_range(1, 16);
      f.pat = ($urandom_range(0, 9) == 0) ? PAT_CHECKER : PAT_RANDOM;
      f.pix_tail = 1'($urandom_range(0, 1));
      f.zero_exp = 0;
      run_frame(f, sent);
      sent_items += sent;
    end
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  // Receive side: random stall bursts, compare every accepted word.
  int stall_left = 0;
  always @(posedge clk_i) begin
    blur_word_t want;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
    if (out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word b=%0d g=%0d r=%0d end=%0b", $time,
                 out_blue_o, out_green_o, out_red_o, frame_end_o);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (out_blue_o !== want.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, out_blue_o);
          errors++;
        end
        if (out_green_o !== want.green) begin
          $display("%0t: green expected %0d actual %0d", $time, want.green, out_green_o);
          errors++;
        end
        if (out_red_o !== want.red) begin
          $display("%0t: red expected %0d actual %0d", $time, want.red, out_red_o);
          errors++;
        end
        if (frame_end_o !== want.fend) begin
          $display("%0t: frame_end expected %0b actual %0b", $time, want.fend,
                   frame_end_o);
          errors++;
        end
      end
    end
    if (calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

endmodule
